@@ hdl/efr_pkg.sv @@
// ----------------------------------------------------------------------------
// efr_pkg
// shared types and constants of the escaped frame receiver and forwarder
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int unsigned DEFAULT_FIFO_DEPTH = 5;

  localparam logic [7:0] DELIM_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE   = 8'h7d;

  // register addresses on the configuration port
  localparam logic REG_OWN_ID = 1'b0;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_POP     = 2'd1,
    OP_SEND    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // one accepted item as handed from the deframer to the emitter
  typedef struct packed {
    logic       tx_en;
    logic [7:0] tx_id;
    logic [7:0] tx_pay;
    logic       tx_esc;
    logic       pop_valid;
    logic       has_data;
    logic [2:0] free_space;
    logic       overflow;
  } job_t;

endpackage

@@ hdl/efr_fifo_mem.sv @@
// ----------------------------------------------------------------------------
// efr_fifo_mem
// receive fifo storage, one write and one registered read port
// ----------------------------------------------------------------------------
module efr_fifo_mem #(
  parameter  int unsigned FIFO_DEPTH = 5,
  localparam int unsigned PtrW       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [PtrW-1:0] waddr_i,
  input  logic [7:0]      wdata_i,
  input  logic            re_i,
  input  logic [PtrW-1:0] raddr_i,
  output logic [7:0]      rdata_o
);

  logic [7:0] mem_q [FIFO_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/efr_deframer.sv @@
// ----------------------------------------------------------------------------
// efr_deframer
// receive framing state, fifo pointers and per-item decisions
// ----------------------------------------------------------------------------
module efr_deframer #(
  parameter  int unsigned FIFO_DEPTH = 5,
  localparam int unsigned PtrW       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int unsigned CntW       = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       operation_i,
  input  logic [7:0]       byte_value_i,
  input  logic [7:0]       dest_id_i,
  input  logic [7:0]       own_id_i,
  output efr_pkg::job_t    job_o,
  output logic             mem_we_o,
  output logic [PtrW-1:0]  mem_waddr_o,
  output logic [7:0]       mem_wdata_o,
  output logic             mem_re_o,
  output logic [PtrW-1:0]  mem_raddr_o
);

  import efr_pkg::*;

  localparam int unsigned SumW  = CntW + 1;
  localparam int unsigned FreeW = CntW + 3;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_DATA = 2'd1,
    MODE_ESC  = 2'd2
  } mode_e;

  mode_e           mode_q, mode_d;
  logic            idx_q, idx_d;
  logic [7:0]      fb0_q;
  logic            fb0_we;
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      data_v;
  logic [SumW-1:0] wr_sum;
  logic [SumW-1:0] wr_wrap;
  logic [FreeW-1:0] free_full;
  job_t            job;

  assign data_v = (mode_q == MODE_ESC) ? ~byte_value_i : byte_value_i;

  // tail address, head + count wraps at most once
  assign wr_sum  = SumW'(head_q) + SumW'(count_q);
  assign wr_wrap = (wr_sum >= SumW'(FIFO_DEPTH)) ? (wr_sum - SumW'(FIFO_DEPTH)) : wr_sum;

  always_comb begin
    mode_d         = mode_q;
    idx_d          = idx_q;
    fb0_we         = 1'b0;
    head_d         = head_q;
    count_d        = count_q;
    mem_we_o       = 1'b0;
    mem_re_o       = 1'b0;
    job            = '0;
    job.tx_id      = dest_id_i;
    job.tx_pay     = byte_value_i;
    if (accept_i) begin
      case (op_e'(operation_i))
        OP_RX_BYTE: begin
          if (byte_value_i == DELIM_BYTE) begin
            mode_d = MODE_DATA;
            idx_d  = 1'b0;
          end else if (byte_value_i == ESC_BYTE) begin
            mode_d = MODE_ESC;
          end else if (mode_q != MODE_WAIT) begin
            if (!idx_q) begin
              fb0_we = 1'b1;
              idx_d  = 1'b1;
            end else begin
              // frame complete: keep locally or forward
              mode_d = MODE_WAIT;
              idx_d  = 1'b0;
              if (fb0_q == own_id_i) begin
                if (count_q != CntW'(FIFO_DEPTH)) begin
                  mem_we_o = 1'b1;
                  count_d  = count_q + 1'b1;
                end else begin
                  job.overflow = 1'b1;
                end
              end else begin
                job.tx_en  = 1'b1;
                job.tx_id  = fb0_q;
                job.tx_pay = data_v;
              end
            end
          end
        end
        OP_POP: begin
          if (count_q != '0) begin
            mem_re_o      = 1'b1;
            job.pop_valid = 1'b1;
            head_d        = (head_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
            count_d       = count_q - 1'b1;
          end
        end
        OP_SEND: begin
          job.tx_en = 1'b1;
        end
        default: ;
      endcase
    end
    job.tx_esc     = (job.tx_pay == DELIM_BYTE) || (job.tx_pay == ESC_BYTE);
    job.has_data   = (count_d != '0);
    job.free_space = free_full[2:0];
  end

  assign free_full   = FreeW'(FIFO_DEPTH) - FreeW'(count_d);
  assign mem_waddr_o = wr_wrap[PtrW-1:0];
  assign mem_wdata_o = data_v;
  assign mem_raddr_o = head_q;
  assign job_o       = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_WAIT;
      idx_q   <= 1'b0;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      idx_q   <= idx_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fb0_we) begin
      fb0_q <= data_v;
    end
  end

endmodule

@@ hdl/efr_emitter.sv @@
// ----------------------------------------------------------------------------
// efr_emitter
// output register, steps through the line bytes of one item
// ----------------------------------------------------------------------------
module efr_emitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  efr_pkg::job_t job_i,
  input  logic [7:0]    pop_data_i,
  output logic          busy_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          tx_valid_o,
  output logic [7:0]    tx_byte_o,
  output logic          last_o,
  output logic          popped_valid_o,
  output logic [7:0]    popped_byte_o,
  output logic          has_data_o,
  output logic [2:0]    free_space_o,
  output logic          overflow_o
);

  import efr_pkg::*;

  logic       valid_q;
  logic [1:0] k_q;
  job_t       job_q;
  logic [1:0] last_k;
  logic       is_last;
  logic       xfer;

  assign last_k  = !job_q.tx_en ? 2'd0 : (job_q.tx_esc ? 2'd3 : 2'd2);
  assign is_last = (k_q == last_k);
  assign xfer    = valid_q && !out_stall_i;
  assign busy_o  = valid_q && !(xfer && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      k_q     <= '0;
    end else if (xfer) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

  always_comb begin
    tx_byte_o = '0;
    if (job_q.tx_en) begin
      case (k_q)
        2'd0:    tx_byte_o = DELIM_BYTE;
        2'd1:    tx_byte_o = job_q.tx_id;
        2'd2:    tx_byte_o = job_q.tx_esc ? ESC_BYTE : job_q.tx_pay;
        default: tx_byte_o = ~job_q.tx_pay;
      endcase
    end
  end

  assign out_valid_o    = valid_q;
  assign tx_valid_o     = job_q.tx_en;
  assign last_o         = is_last;
  assign popped_valid_o = job_q.pop_valid;
  assign popped_byte_o  = job_q.pop_valid ? pop_data_i : 8'h00;
  assign has_data_o     = job_q.has_data;
  assign free_space_o   = job_q.free_space;
  assign overflow_o     = job_q.overflow;

endmodule

@@ hdl/escaped_frame_receiver_forwarder_unit.sv @@
// ----------------------------------------------------------------------------
// escaped_frame_receiver_forwarder_unit
// byte-stuffed frame receiver with local receive fifo and frame forwarding
// ----------------------------------------------------------------------------
// output: an item's first result is presented in the cycle after its transfer
// throughput: one item per cycle while out_stall_i is low, for items that give a
//   single status result; a forwarded or sent frame holds the output register for
//   3 or 4 line bytes, one per unstalled cycle, paced by the emitter's byte counter
// reset: framing state, fifo pointers and own_id clear; fifo contents stay
//   undefined and are never read before being written, so no clearing pass
module escaped_frame_receiver_forwarder_unit #(
  parameter int unsigned FIFO_DEPTH = efr_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  byte_value_i,
  input  logic [7:0]  dest_id_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic        popped_valid_o,
  output logic [7:0]  popped_byte_o,
  output logic        has_data_o,
  output logic [2:0]  free_space_o,
  output logic        overflow_o
);

  import efr_pkg::*;

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic [7:0]      own_id_q;
  logic            cfg_wr;
  logic            accept;
  logic            busy;
  job_t            job;
  logic            mem_we;
  logic [PtrW-1:0] mem_waddr;
  logic [7:0]      mem_wdata;
  logic            mem_re;
  logic [PtrW-1:0] mem_raddr;
  logic [7:0]      mem_rdata;

  // configuration: a single register, decoded on the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OWN_ID);
  assign prdata = (paddr[2] == REG_OWN_ID) ? {24'h0, own_id_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
    end else if (cfg_wr) begin
      own_id_q <= pwdata[7:0];
    end
  end

  // a new item enters while the output register is free or is handing over
  // its final result in this same cycle
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  // framing state, fifo pointers; reads and writes of the fifo memory are
  // issued at the item's transfer, so the popped byte is ready with the result
  efr_deframer #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_deframer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .byte_value_i (byte_value_i),
    .dest_id_i    (dest_id_i),
    .own_id_i     (own_id_q),
    .job_o        (job),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr)
  );

  // receive fifo storage; a pop only reads entries written at an earlier
  // transfer, so no forwarding path is needed
  efr_fifo_mem #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register and line byte sequencing
  efr_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .job_i          (job),
    .pop_data_i     (mem_rdata),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tx_valid_o     (tx_valid_o),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .popped_valid_o (popped_valid_o),
    .popped_byte_o  (popped_byte_o),
    .has_data_o     (has_data_o),
    .free_space_o   (free_space_o),
    .overflow_o     (overflow_o)
  );

endmodule
